>>> hw/rtl/bls_pkg.sv
// Shared types and constants for the bounded LIFO stack.
// Used by the channel interfaces, the controller and the datapath.
package bls_pkg;

  localparam int DATA_W      = 32;
  localparam int OP_W        = 2;
  localparam int POS_W       = 5;
  localparam int CAP_W       = 5;
  localparam int DEPTH_NOW_W = 5;
  localparam int STATUS_W    = 2;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_OVER   = 2'd1,
    ST_UNDER  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic fetch;
  } cmd_t;

endpackage

>>> hw/rtl/bls_if.sv
// Request and response channels of the bounded LIFO stack.
// Depends on bls_pkg for field widths.
interface bls_req_if;
  logic                            valid;
  logic                            ready;
  logic [bls_pkg::OP_W-1:0]        operation;
  logic signed [bls_pkg::DATA_W-1:0] push_value;
  logic [bls_pkg::POS_W-1:0]       position;

  modport source (output valid, operation, push_value, position, input ready);
  modport sink   (input valid, operation, push_value, position, output ready);
endinterface

interface bls_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bls_pkg::DATA_W-1:0]    read_value;
  logic [bls_pkg::STATUS_W-1:0]         status;
  logic [bls_pkg::DEPTH_NOW_W-1:0]      depth_now;

  modport source (output valid, read_value, status, depth_now, input ready);
  modport sink   (input valid, read_value, status, depth_now, output ready);
endinterface

>>> hw/rtl/bounded_lifo_stack_core.sv
// Bounded LIFO stack, top level.
// Depends on bls_pkg, bls_if, bls_ctrl, bls_dpath and bls_ram.
//
// Usage:
//   req carries one request: operation (push, pop, peek), push_value and
//   position. rsp returns one response per request: read_value, status and
//   depth_now (entries held after the request).
//   cfg_we / cfg_data write the capacity register; write it only while idle.
//   Capacity above DEPTH acts as DEPTH; capacity zero makes every push overflow.
//
// Timing:
//   One request is in flight at a time. A request is taken in the idle
//   state, the entry RAM is read on the accepting edge, its registered data
//   is captured into read_value in the fetch state, and the response is
//   valid in the done state. A new request is not taken until the response
//   is accepted; the spacing is set by the registered read of the entry RAM
//   and the single response stage.
//
// Reset (rst, synchronous): stack empty, capacity 16. RAM contents are not
//   cleared. While rsp.ready is low the response holds and req.ready stays low.
module bounded_lifo_stack_core #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  bls_req_if.sink                     req,
  bls_rsp_if.source                   rsp,
  input  logic                        cfg_we,
  input  logic [bls_pkg::CAP_W-1:0]   cfg_data
);

  bls_pkg::cmd_t cmd;

  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  bls_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .operation  (req.operation),
    .push_value (req.push_value),
    .position   (req.position),
    .read_value (rsp.read_value),
    .status     (rsp.status),
    .depth_now  (rsp.depth_now)
  );

endmodule

>>> hw/rtl/bls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/bls_ctrl.sv
// Sequencing controller of the bounded LIFO stack: accept, fetch, deliver.
// Depends on bls_pkg for state and command types.
module bls_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bls_pkg::cmd_t cmd
);

  bls_pkg::state_t state;
  bls_pkg::state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      bls_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = bls_pkg::S_FETCH;
        end
      end
      bls_pkg::S_FETCH: begin
        state_next = bls_pkg::S_DONE;
      end
      bls_pkg::S_DONE: begin
        if (out_ready) begin
          state_next = bls_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bls_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bls_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == bls_pkg::S_IDLE);
  assign out_valid = (state == bls_pkg::S_DONE);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.fetch = (state == bls_pkg::S_FETCH);

  a_fetch_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> out_valid)
    else $error("fetch not followed by delivery");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request taken while response pending");

endmodule

>>> hw/rtl/bls_dpath.sv
// Datapath of the bounded LIFO stack: entry count, capacity, entry RAM, result.
// Depends on bls_pkg and bls_ram.
module bls_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bls_pkg::cmd_t                        cmd,
  input  logic                                 cfg_we,
  input  logic [bls_pkg::CAP_W-1:0]            cfg_data,
  input  logic [bls_pkg::OP_W-1:0]             operation,
  input  logic signed [bls_pkg::DATA_W-1:0]    push_value,
  input  logic [bls_pkg::POS_W-1:0]            position,
  output logic signed [bls_pkg::DATA_W-1:0]    read_value,
  output logic [bls_pkg::STATUS_W-1:0]         status,
  output logic [bls_pkg::DEPTH_NOW_W-1:0]      depth_now
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > bls_pkg::POS_W) ? CW : bls_pkg::POS_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] DEPTH_W = PW'(DEPTH);

  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;
  logic [bls_pkg::CAP_W-1:0]   capacity;
  bls_pkg::status_t            status_q;
  bls_pkg::status_t            status_next;
  logic                        use_mem;
  logic                        re;
  logic                        we;
  logic [AW-1:0]               raddr;
  logic [bls_pkg::DATA_W-1:0]  rdata;
  logic [PW-1:0]               count_w;
  logic [PW-1:0]               pos_w;
  logic [PW-1:0]               cap_w;
  logic [PW-1:0]               limit;
  logic [PW-1:0]               pop_idx;
  logic [PW-1:0]               peek_idx;
  bls_pkg::op_t                op;

  assign count_w  = PW'(count);
  assign pos_w    = PW'(position);
  assign cap_w    = PW'(capacity);
  assign limit    = (cap_w > DEPTH_W) ? DEPTH_W : cap_w;
  assign pop_idx  = count_w - PW'(1);
  assign peek_idx = count_w - pos_w;
  assign op       = bls_pkg::op_t'(operation);

  always_comb begin
    count_next  = count;
    status_next = bls_pkg::ST_OK;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = pop_idx[AW-1:0];
    case (op)
      bls_pkg::OP_PUSH: begin
        if (count_w >= limit) begin
          status_next = bls_pkg::ST_OVER;
        end else begin
          we         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      bls_pkg::OP_POP: begin
        if (count_w == '0) begin
          status_next = bls_pkg::ST_UNDER;
        end else begin
          re         = 1'b1;
          count_next = count - CW'(1);
        end
      end
      bls_pkg::OP_PEEK: begin
        raddr = peek_idx[AW-1:0];
        if (pos_w == '0 || pos_w > count_w) begin
          status_next = bls_pkg::ST_BADPOS;
        end else begin
          re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  bls_ram #(
    .WIDTH (bls_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we && cmd.load),
    .waddr (count_w[AW-1:0]),
    .wdata (push_value),
    .re    (re && cmd.load),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= bls_pkg::CAP_RESET;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (cmd.load) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_q <= status_next;
      use_mem  <= re;
    end
    if (cmd.fetch) begin
      read_value <= use_mem ? $signed(rdata) : $signed(bls_pkg::ALL_ONES);
    end
  end

  assign status    = status_q;
  assign depth_now = count_w[bls_pkg::DEPTH_NOW_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_w <= DEPTH_W)
    else $error("entry count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.load |=> $stable(count))
    else $error("entry count changed without a request");

endmodule
